FILE: rtl/core/iuhb_pkg.sv
`default_nettype none

package iuhb_pkg;

    // One payload request
    typedef struct packed {
        logic [7:0] payload_byte;
        logic       byte_valid;
        logic       last_byte;
    } in_t;

    // One header word
    typedef struct packed {
        logic [15:0] header_word;
        logic [3:0]  word_index;
        logic        last_word;
        logic        length_overflow;
    } out_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_SRC_ADDR = 2'd0,
        CFG_DST_ADDR = 2'd1,
        CFG_SRC_PORT = 2'd2,
        CFG_DST_PORT = 2'd3
    } cfg_idx_t;

    // Header word positions
    localparam logic [3:0] W_VER_TOS   = 4'd0;
    localparam logic [3:0] W_TOT_LEN   = 4'd1;
    localparam logic [3:0] W_IDENT     = 4'd2;
    localparam logic [3:0] W_FLAGS     = 4'd3;
    localparam logic [3:0] W_TTL_PROTO = 4'd4;
    localparam logic [3:0] W_IP_CSUM   = 4'd5;
    localparam logic [3:0] W_SRC_HI    = 4'd6;
    localparam logic [3:0] W_SRC_LO    = 4'd7;
    localparam logic [3:0] W_DST_HI    = 4'd8;
    localparam logic [3:0] W_DST_LO    = 4'd9;
    localparam logic [3:0] W_SRC_PORT  = 4'd10;
    localparam logic [3:0] W_DST_PORT  = 4'd11;
    localparam logic [3:0] W_UDP_LEN   = 4'd12;
    localparam logic [3:0] W_UDP_CSUM  = 4'd13;

    // Fixed header fields
    localparam logic [15:0] VER_TOS   = 16'h4500;
    localparam logic [15:0] IDENT     = 16'h0001;
    localparam logic [15:0] FLAGS     = 16'h0000;
    localparam logic [15:0] TTL_PROTO = 16'h1111;
    localparam logic [15:0] PROTO_UDP = 16'h0011;
    localparam logic [15:0] IP_HDR_LEN  = 16'd20;
    localparam logic [15:0] UDP_HDR_LEN = 16'd8;

    // Sum of the fixed IPv4 header words
    localparam logic [19:0] IP_FIXED_SUM =
        20'(VER_TOS) + 20'(IDENT) + 20'(FLAGS) + 20'(TTL_PROTO);

    // Ones' complement add of two 16-bit words with end-around carry
    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

    // Fold a 20-bit plain sum into a 16-bit ones' complement sum
    function automatic logic [15:0] oc_fold(input logic [19:0] x);
        logic [16:0] f;
        f = {1'b0, x[15:0]} + {13'd0, x[19:16]};
        return f[15:0] + {15'd0, f[16]};
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/ipv4_udp_header_builder.sv
// Flow: the closing request passes stages 1-3 and the header stage, then the first header
// word enters the output register; the 14 words follow one per cycle while m_ready is high.
// Throughput: one payload request per cycle. A closing request waits while the previous
// header is still in the checksum pipeline or being sent, output stalls included.
// Reset: synchronous, active low; clears configuration, running sum, count and all valids.
`default_nettype none

module ipv4_udp_header_builder #(
    parameter int MAX_PAYLOAD = 65507
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,

    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire iuhb_pkg::in_t  s_data,

    output logic                m_valid,
    input  wire logic           m_ready,
    output iuhb_pkg::out_t      m_data,

    input  wire logic           cfg_we,
    input  wire logic [1:0]     cfg_index,
    input  wire logic [31:0]    cfg_wdata
);

    localparam logic [15:0] MAX_LEN = 16'(MAX_PAYLOAD);
    localparam logic [3:0]  LAST_IDX = iuhb_pkg::W_UDP_CSUM;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [31:0] src_addr_reg;
    logic [31:0] dst_addr_reg;
    logic [15:0] src_port_reg;
    logic [15:0] dst_port_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_addr_reg <= '0;
            dst_addr_reg <= '0;
            src_port_reg <= '0;
            dst_port_reg <= '0;
        end else if (cfg_we) begin
            unique case (iuhb_pkg::cfg_idx_t'(cfg_index))
                iuhb_pkg::CFG_SRC_ADDR: src_addr_reg <= cfg_wdata;
                iuhb_pkg::CFG_DST_ADDR: dst_addr_reg <= cfg_wdata;
                iuhb_pkg::CFG_SRC_PORT: src_port_reg <= cfg_wdata[15:0];
                iuhb_pkg::CFG_DST_PORT: dst_port_reg <= cfg_wdata[15:0];
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Payload accumulator: running sum, pairing of octets and byte count
    // ------------------------------------------------------------------
    logic [15:0] sum_reg,  sum_next;
    logic [15:0] count_reg, count_next;
    logic        odd_reg,  odd_next;
    logic [7:0]  held_reg, held_next;
    logic        ovf_reg,  ovf_next;
    logic [15:0] add_term;
    logic        at_max;
    logic        s_fire;

    // Pipeline and emission valids
    logic        p1_vld_reg, p2_vld_reg, p3_vld_reg, emit_vld_reg;
    logic        close_busy;

    // Hold a closing request while an earlier header is still in flight;
    // payload requests keep flowing into the accumulator meanwhile.
    assign close_busy = p1_vld_reg | p2_vld_reg | p3_vld_reg | emit_vld_reg;
    assign s_ready    = !(s_data.last_byte && close_busy);
    assign s_fire     = s_valid && s_ready;

    assign at_max = (count_reg >= MAX_LEN);

    // At most one ones' complement add per request: the completed pair, or on a
    // close the lone high byte padded with a zero low byte.
    always_comb begin
        add_term = '0;
        if (s_data.byte_valid && odd_reg) begin
            add_term = {held_reg, s_data.payload_byte};
        end else if (s_data.last_byte && s_data.byte_valid) begin
            add_term = {s_data.payload_byte, 8'h00};
        end else if (s_data.last_byte && odd_reg) begin
            add_term = {held_reg, 8'h00};
        end
    end

    always_comb begin
        sum_next   = iuhb_pkg::oc_add(sum_reg, add_term);
        count_next = count_reg;
        ovf_next   = ovf_reg;
        odd_next   = odd_reg;
        held_next  = held_reg;
        if (s_data.byte_valid) begin
            // Saturate the count and flag the oversize payload
            if (at_max) begin
                count_next = MAX_LEN;
                ovf_next   = 1'b1;
            end else begin
                count_next = count_reg + 16'd1;
            end
            if (odd_reg) begin
                odd_next  = 1'b0;
                held_next = '0;
            end else begin
                odd_next  = 1'b1;
                held_next = s_data.payload_byte;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg   <= '0;
            count_reg <= '0;
            odd_reg   <= 1'b0;
            held_reg  <= '0;
            ovf_reg   <= 1'b0;
        end else if (s_fire) begin
            if (s_data.last_byte) begin
                // Closing request: drop the datagram state
                sum_reg   <= '0;
                count_reg <= '0;
                odd_reg   <= 1'b0;
                held_reg  <= '0;
                ovf_reg   <= 1'b0;
            end else begin
                sum_reg   <= sum_next;
                count_reg <= count_next;
                odd_reg   <= odd_next;
                held_reg  <= held_next;
                ovf_reg   <= ovf_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Checksum pipeline
    // Stage 1 captures the closed datagram, stage 2 forms lengths and the
    // address sum, stage 3 forms both plain sums, the header stage folds and
    // inverts them.
    // ------------------------------------------------------------------
    logic [15:0] p1_len_reg;
    logic [15:0] p1_pay_reg;
    logic        p1_ovf_reg;

    logic [17:0] p2_addr_reg;
    logic [15:0] p2_tot_reg;
    logic [15:0] p2_udpl_reg;
    logic [15:0] p2_pay_reg;
    logic        p2_ovf_reg;

    logic [19:0] p3_ip_reg;
    logic [19:0] p3_udp_reg;
    logic [15:0] p3_tot_reg;
    logic [15:0] p3_udpl_reg;
    logic        p3_ovf_reg;

    logic [15:0] h_ip_csum_reg;
    logic [15:0] h_udp_csum_reg;
    logic [15:0] h_tot_reg;
    logic [15:0] h_udpl_reg;
    logic        h_ovf_reg;
    logic [3:0]  idx_reg, idx_next;

    logic        out_load;
    logic        emit_vld_next;

    always_ff @(posedge aclk) begin
        if (s_fire && s_data.last_byte) begin
            p1_len_reg <= count_next;
            p1_pay_reg <= sum_next;
            p1_ovf_reg <= ovf_next;
        end
        if (p1_vld_reg) begin
            p2_addr_reg <= 18'(src_addr_reg[31:16]) + 18'(src_addr_reg[15:0])
                         + 18'(dst_addr_reg[31:16]) + 18'(dst_addr_reg[15:0]);
            p2_tot_reg  <= p1_len_reg + iuhb_pkg::IP_HDR_LEN + iuhb_pkg::UDP_HDR_LEN;
            p2_udpl_reg <= p1_len_reg + iuhb_pkg::UDP_HDR_LEN;
            p2_pay_reg  <= p1_pay_reg;
            p2_ovf_reg  <= p1_ovf_reg;
        end
        if (p2_vld_reg) begin
            p3_ip_reg   <= 20'(p2_addr_reg) + 20'(p2_tot_reg) + iuhb_pkg::IP_FIXED_SUM;
            // Pseudo-header, UDP header (length counted twice) and payload
            p3_udp_reg  <= 20'(p2_addr_reg) + 20'(iuhb_pkg::PROTO_UDP)
                         + 20'(p2_udpl_reg) + 20'(p2_udpl_reg)
                         + 20'(src_port_reg) + 20'(dst_port_reg) + 20'(p2_pay_reg);
            p3_tot_reg  <= p2_tot_reg;
            p3_udpl_reg <= p2_udpl_reg;
            p3_ovf_reg  <= p2_ovf_reg;
        end
        if (p3_vld_reg) begin
            h_ip_csum_reg  <= ~iuhb_pkg::oc_fold(p3_ip_reg);
            h_udp_csum_reg <= ~iuhb_pkg::oc_fold(p3_udp_reg);
            h_tot_reg      <= p3_tot_reg;
            h_udpl_reg     <= p3_udpl_reg;
            h_ovf_reg      <= p3_ovf_reg;
        end
    end

    // ------------------------------------------------------------------
    // Header emission into the output register
    // ------------------------------------------------------------------
    logic [15:0]    word_sel;
    iuhb_pkg::out_t m_data_reg;
    logic           m_valid_reg, m_valid_next;

    assign out_load = emit_vld_reg && (!m_valid_reg || m_ready);

    always_comb begin
        unique case (idx_reg)
            iuhb_pkg::W_VER_TOS:   word_sel = iuhb_pkg::VER_TOS;
            iuhb_pkg::W_TOT_LEN:   word_sel = h_tot_reg;
            iuhb_pkg::W_IDENT:     word_sel = iuhb_pkg::IDENT;
            iuhb_pkg::W_FLAGS:     word_sel = iuhb_pkg::FLAGS;
            iuhb_pkg::W_TTL_PROTO: word_sel = iuhb_pkg::TTL_PROTO;
            iuhb_pkg::W_IP_CSUM:   word_sel = h_ip_csum_reg;
            iuhb_pkg::W_SRC_HI:    word_sel = src_addr_reg[31:16];
            iuhb_pkg::W_SRC_LO:    word_sel = src_addr_reg[15:0];
            iuhb_pkg::W_DST_HI:    word_sel = dst_addr_reg[31:16];
            iuhb_pkg::W_DST_LO:    word_sel = dst_addr_reg[15:0];
            iuhb_pkg::W_SRC_PORT:  word_sel = src_port_reg;
            iuhb_pkg::W_DST_PORT:  word_sel = dst_port_reg;
            iuhb_pkg::W_UDP_LEN:   word_sel = h_udpl_reg;
            iuhb_pkg::W_UDP_CSUM:  word_sel = h_udp_csum_reg;
            default:               word_sel = '0;
        endcase
    end

    always_comb begin
        idx_next      = idx_reg;
        emit_vld_next = emit_vld_reg;
        if (p3_vld_reg) begin
            // New header ready: restart at the first word
            idx_next      = '0;
            emit_vld_next = 1'b1;
        end else if (out_load) begin
            if (idx_reg == LAST_IDX) begin
                idx_next      = '0;
                emit_vld_next = 1'b0;
            end else begin
                idx_next = idx_reg + 4'd1;
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_vld_reg   <= 1'b0;
            p2_vld_reg   <= 1'b0;
            p3_vld_reg   <= 1'b0;
            emit_vld_reg <= 1'b0;
            idx_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            p1_vld_reg   <= s_fire && s_data.last_byte;
            p2_vld_reg   <= p1_vld_reg;
            p3_vld_reg   <= p2_vld_reg;
            emit_vld_reg <= emit_vld_next;
            idx_reg      <= idx_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg.header_word     <= word_sel;
            m_data_reg.word_index      <= idx_reg;
            m_data_reg.last_word       <= (idx_reg == LAST_IDX);
            m_data_reg.length_overflow <= h_ovf_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire
